FILE: hw/rtl/card_reader_frame_parser_assert.svh
// Assertion macros shared by the card reader frame parser modules.
`ifndef CARD_READER_FRAME_PARSER_ASSERT_SVH
`define CARD_READER_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRFP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CRFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/crfp_pkg.sv
// Shared types and constants for the card reader frame parser.
package crfp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] evt_code_t;
    typedef logic [1:0] flag_t;

    localparam int MAX_FRAME_LEN_DEF = 31;
    localparam int BLOCK_BYTES_DEF   = 16;
    localparam int BLOCK_MAX         = 16;

    localparam int BUF_DEPTH    = 32;
    localparam int BUF_AW       = 5;
    localparam int BLOCK_OFFSET = 9;

    localparam byte_t HDR_BYTE    = 8'h7F;
    localparam byte_t REPLY_CARD  = 8'h90;
    localparam byte_t REPLY_BLOCK = 8'h91;
    localparam byte_t STATUS_OK   = 8'h00;

    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_FLAG = 1'b1;

    localparam evt_code_t EV_NONE  = 2'd0;
    localparam evt_code_t EV_BLOCK = 2'd1;
    localparam evt_code_t EV_CARD  = 2'd2;
    localparam evt_code_t EV_ERROR = 2'd3;

    localparam flag_t FLAG_NONE    = 2'd0;
    localparam flag_t FLAG_PRESENT = 2'd1;
    localparam flag_t FLAG_BLOCK   = 2'd2;
    localparam flag_t FLAG_HOLD    = 2'd3;

endpackage

FILE: hw/rtl/crfp_parser.sv
// Frame parser: header/length tracking, frame buffer and block data store.
`include "card_reader_frame_parser_assert.svh"

module crfp_parser
    import crfp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     feed_en,
    input  byte_t                    rx_byte,
    output evt_code_t                evt_code,
    output logic [BLOCK_MAX*8-1:0]   blk_flat
);

    // Length bytes at or above the header value are ignored, so the counter
    // never needs to hold more than one below it.
    localparam int LEN_CAP = (MAX_FRAME_LEN < int'(HDR_BYTE)) ? MAX_FRAME_LEN
                                                              : int'(HDR_BYTE) - 1;
    localparam int BL_W = $clog2(LEN_CAP + 1);
    localparam logic [8:0]      MAX_LEN_9 = 9'(MAX_FRAME_LEN);
    localparam logic [BL_W-1:0] BL_ONE    = BL_W'(1);

    logic              in_frame_reg, in_frame_next;
    logic [BL_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [BUF_AW-1:0] write_index_reg, write_index_next;
    byte_t             buf_reg [BUF_DEPTH];
    byte_t             block_reg [BLOCK_BYTES];
    logic              buf_we;
    logic              blk_we;

    always_comb begin
        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        write_index_next = write_index_reg;
        buf_we           = 1'b0;
        blk_we           = 1'b0;
        evt_code         = EV_NONE;
        if (feed_en) begin
            if (!in_frame_reg) begin
                if (rx_byte == HDR_BYTE) begin
                    in_frame_next    = 1'b1;
                    bytes_left_next  = '0;
                    write_index_next = '0;
                end
            end else if (bytes_left_reg == '0) begin
                if (rx_byte < HDR_BYTE) begin
                    // drop the frame on an oversize length
                    if ({1'b0, rx_byte} > MAX_LEN_9) begin
                        in_frame_next    = 1'b0;
                        write_index_next = '0;
                    end else begin
                        bytes_left_next = rx_byte[BL_W-1:0];
                    end
                end
            end else if (bytes_left_reg != BL_ONE) begin
                bytes_left_next  = bytes_left_reg - BL_ONE;
                buf_we           = 1'b1;
                write_index_next = write_index_reg + BUF_AW'(1);
            end else begin
                // final byte: decode reply code and status as the buffer stands
                bytes_left_next = '0;
                in_frame_next   = 1'b0;
                if (buf_reg[1] == REPLY_CARD) begin
                    evt_code = (buf_reg[2] == STATUS_OK) ? EV_CARD : EV_ERROR;
                end else if (buf_reg[1] == REPLY_BLOCK) begin
                    if (buf_reg[2] != STATUS_OK) begin
                        evt_code = EV_ERROR;
                    end else begin
                        evt_code = EV_BLOCK;
                        blk_we   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= '0;
            write_index_reg <= '0;
        end else begin
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            write_index_reg <= write_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                buf_reg[i] <= '0;
            end
        end else if (buf_we) begin
            buf_reg[write_index_reg] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                block_reg[k] <= '0;
            end
        end else if (blk_we) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                block_reg[k] <= buf_reg[BUF_AW'(BLOCK_OFFSET + k)];
            end
        end
    end

    for (genvar g = 0; g < BLOCK_MAX; g++) begin : g_block
        if (g < BLOCK_BYTES) begin : g_used
            assign blk_flat[g*8 +: 8] = block_reg[g];
        end else begin : g_zero
            assign blk_flat[g*8 +: 8] = '0;
        end
    end

    `CRFP_ASSERT_NOW(a_len_in_frame, aclk, aresetn, bytes_left_reg != '0, in_frame_reg)
    `CRFP_ASSERT_NEXT(a_event_ends_frame, aclk, aresetn, evt_code != EV_NONE,
                      !in_frame_reg && bytes_left_reg == '0)

endmodule

FILE: hw/rtl/crfp_status.sv
// Status flag and card timestamp, updated from parser events and flag writes.
`include "card_reader_frame_parser_assert.svh"

module crfp_status
    import crfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_en,
    input  logic        action,
    input  logic [31:0] now_ms,
    input  flag_t       new_flag,
    input  evt_code_t   evt_code,
    output flag_t       status_flag,
    output logic [31:0] last_card_time
);

    flag_t       flag_reg, flag_next;
    logic [31:0] card_time_reg, card_time_next;

    always_comb begin
        flag_next      = flag_reg;
        card_time_next = card_time_reg;
        if (item_en) begin
            if (action == ACT_FLAG) begin
                flag_next = new_flag;
            end else begin
                unique case (evt_code)
                    EV_BLOCK: flag_next = FLAG_BLOCK;
                    EV_CARD: begin
                        // hold keeps the flag and stamps the time instead
                        if (flag_reg != FLAG_HOLD) begin
                            flag_next = FLAG_PRESENT;
                        end else begin
                            card_time_next = now_ms;
                        end
                    end
                    EV_ERROR: begin
                        if (flag_reg != FLAG_HOLD) begin
                            flag_next = FLAG_NONE;
                        end
                    end
                    default: flag_next = flag_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg      <= FLAG_NONE;
            card_time_reg <= '0;
        end else begin
            flag_reg      <= flag_next;
            card_time_reg <= card_time_next;
        end
    end

    assign status_flag    = flag_reg;
    assign last_card_time = card_time_reg;

    `CRFP_ASSERT_NEXT(a_hold_kept_on_card, aclk, aresetn,
                      item_en && action == ACT_FEED && evt_code == EV_CARD
                      && flag_reg == FLAG_HOLD,
                      flag_reg == FLAG_HOLD && card_time_reg == $past(now_ms))

endmodule

FILE: hw/rtl/card_reader_frame_parser.sv
// Card reader frame parser top level: stream channels, input and result registers.
//
// Input channel s_*: one transaction per received byte or flag write. s_tuser
// is the action (0 feed s_tdata byte to the parser, 1 write the status flag).
// Result channel m_*: exactly one transaction per input transaction, carrying
// the event code, the status flag after the item, the last hold-state card
// time and the 16 bytes of block data.
// Each item is held in the input register while the parse logic computes the
// value loaded into the result register. Throughput: one transaction per cycle
// while the receiver does not stall; the parser and flag update logic between
// the two registers is combinational.
// Reset (aresetn low, synchronous): both channels empty, parser waiting for a
// header, frame buffer and block data cleared, flag none, card time zero.
// When the receiver stalls, the result is held and the next item waits in the
// input register; s_tready drops only once that register is also full.
`include "card_reader_frame_parser_assert.svh"

module card_reader_frame_parser
    import crfp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8], new_flag[41:40], zero
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // event_res[1:0], status_flag[3:2],
                                    // last_card_time[35:4], block_low[99:36],
                                    // block_high[163:100], zero
);

    logic        in_valid_reg;
    logic        in_action_reg;
    byte_t       in_byte_reg;
    logic [31:0] in_now_reg;
    flag_t       in_flag_reg;

    logic        out_valid_reg;
    evt_code_t   out_event_reg;

    logic        advance;
    logic        s_take;
    evt_code_t   evt_code;
    flag_t       status_flag;
    logic [31:0] last_card_time;
    logic [BLOCK_MAX*8-1:0] blk_flat;

    // process the held item when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata[7:0];
            in_now_reg    <= s_tdata[39:8];
            in_flag_reg   <= s_tdata[41:40];
        end
    end

    crfp_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .BLOCK_BYTES   (BLOCK_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .feed_en    (advance && in_action_reg == ACT_FEED),
        .rx_byte    (in_byte_reg),
        .evt_code   (evt_code),
        .blk_flat   (blk_flat)
    );

    crfp_status u_status (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_en        (advance),
        .action         (in_action_reg),
        .now_ms         (in_now_reg),
        .new_flag       (in_flag_reg),
        .evt_code       (evt_code),
        .status_flag    (status_flag),
        .last_card_time (last_card_time)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= evt_code;
        end
    end

    // state only moves on advance, so while a result waits the state registers
    // still hold the values left by that item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, blk_flat, last_card_time, status_flag, out_event_reg};

    `CRFP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_tready)
    `CRFP_ASSERT_NEXT(a_state_held_on_stall, aclk, aresetn,
                      out_valid_reg && !m_tready,
                      $stable(status_flag) && $stable(last_card_time)
                      && $stable(blk_flat))

endmodule
